// ----- src/assert_macros.svh -----
// Assertion macros shared by the stack RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger implies a condition in the same cycle.
`define ASSERT_IMPL(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

`endif

// ----- src/bsws_pkg.sv -----
// Shared constants and controller/datapath interface types for the stack.
package bsws_pkg;

    localparam int DEPTH  = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int CMD_W  = 3;
    localparam int STS_W  = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DISPLAY = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd4;

    localparam logic [STS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL     = 2'd1;
    localparam logic [STS_W-1:0] STS_EMPTY    = 2'd2;
    localparam logic [STS_W-1:0] STS_NOTFOUND = 2'd3;

    typedef struct packed {
        logic             load;
        logic             mem_write;
        logic             fill_inc;
        logic             fill_dec;
        logic             idx_load;
        logic             idx_dec;
        logic             emit;
        logic [STS_W-1:0] emit_status;
        logic             emit_data;
        logic             emit_pos;
        logic             emit_last;
    } bsws_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             empty;
        logic             idx_zero;
        logic             match;
        logic             slot_free;
    } bsws_status_t;

endpackage

// ----- src/bsws_datapath.sv -----
// Datapath: stack memory, fill count, scan index, request latch and result register.
module bsws_datapath
    import bsws_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  bsws_cmd_t         ctl,
    output bsws_status_t      sts,
    input  logic [CMD_W-1:0]  in_cmd,
    input  logic [DATA_W-1:0] in_value,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [STS_W-1:0]  out_status,
    output logic [DATA_W-1:0] out_data,
    output logic [POS_W-1:0]  out_pos,
    output logic              out_last
);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [DATA_W-1:0] val_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;
    logic [CNT_W-1:0]  fill_m1;
    logic [ADDR_W:0]   pos_full;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [STS_W-1:0]  out_status_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic              out_last_reg;

    assign fill_m1  = fill_reg - CNT_W'(1);
    assign pos_full = {1'b0, idx_reg} + (ADDR_W + 1)'(1);

    always_ff @(posedge clk)
    begin
        if (ctl.mem_write)
        begin
            mem[fill_reg[ADDR_W-1:0]] <= val_reg;
        end
        rdata_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= in_cmd;
            val_reg <= in_value;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (ctl.fill_inc)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (ctl.fill_dec)
        begin
            fill_next = fill_m1;
        end
        idx_next = idx_reg;
        if (ctl.idx_load)
        begin
            idx_next = fill_m1[ADDR_W-1:0];
        end
        else if (ctl.idx_dec)
        begin
            idx_next = idx_reg - ADDR_W'(1);
        end
        out_valid_next = out_valid_reg;
        if (ctl.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_status_reg <= ctl.emit_status;
            out_data_reg   <= ctl.emit_data ? rdata_reg : '0;
            out_pos_reg    <= ctl.emit_pos ? POS_W'(pos_full) : '0;
            out_last_reg   <= ctl.emit_last;
        end
    end

    assign sts.cmd       = cmd_reg;
    assign sts.full      = (fill_reg == DEPTH_CNT);
    assign sts.empty     = (fill_reg == '0);
    assign sts.idx_zero  = (idx_reg == '0);
    assign sts.match     = (rdata_reg == val_reg);
    assign sts.slot_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_data   = out_data_reg;
    assign out_pos    = out_pos_reg;
    assign out_last   = out_last_reg;

endmodule

// ----- src/bsws_controller.sv -----
// Controller: sequences each request through the datapath.
module bsws_controller
    import bsws_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  bsws_status_t sts,
    output bsws_cmd_t    ctl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_EV   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!(sts.cmd inside {[CMD_PUSH:CMD_SEARCH]}))
                begin
                    state_next = S_IDLE;
                end
                else if (sts.cmd == CMD_PUSH)
                begin
                    if (sts.slot_free)
                    begin
                        ctl.emit        = 1'b1;
                        ctl.emit_last   = 1'b1;
                        ctl.emit_status = sts.full ? STS_FULL : STS_OK;
                        ctl.mem_write   = !sts.full;
                        ctl.fill_inc    = !sts.full;
                        state_next      = S_IDLE;
                    end
                end
                else if (sts.empty)
                begin
                    if (sts.slot_free)
                    begin
                        ctl.emit        = 1'b1;
                        ctl.emit_last   = 1'b1;
                        ctl.emit_status = STS_EMPTY;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    ctl.idx_load = 1'b1;
                    state_next   = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_EV;
            end
            S_EV:
            begin
                case (sts.cmd)
                    CMD_POP, CMD_PEEK:
                    begin
                        if (sts.slot_free)
                        begin
                            ctl.emit        = 1'b1;
                            ctl.emit_last   = 1'b1;
                            ctl.emit_data   = 1'b1;
                            ctl.emit_status = STS_OK;
                            ctl.fill_dec    = (sts.cmd == CMD_POP);
                            state_next      = S_IDLE;
                        end
                    end
                    CMD_DISPLAY:
                    begin
                        if (sts.slot_free)
                        begin
                            ctl.emit        = 1'b1;
                            ctl.emit_last   = sts.idx_zero;
                            ctl.emit_data   = 1'b1;
                            ctl.emit_status = STS_OK;
                            ctl.idx_dec     = !sts.idx_zero;
                            state_next      = sts.idx_zero ? S_IDLE : S_RD;
                        end
                    end
                    default:
                    begin
                        if (sts.match || sts.idx_zero)
                        begin
                            if (sts.slot_free)
                            begin
                                ctl.emit        = 1'b1;
                                ctl.emit_last   = 1'b1;
                                ctl.emit_pos    = sts.match;
                                ctl.emit_status = sts.match ? STS_OK : STS_NOTFOUND;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            ctl.idx_dec = 1'b1;
                            state_next  = S_RD;
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/bounded_stack_with_search.sv -----
// Top level of the bounded stack with linear search.
//
// A LIFO of DEPTH (32) signed words. A request is taken only while the
// controller is idle; a result register sits on the output so the next request
// can be taken while a result still waits. Push and an empty-stack request
// finish in the execute state; unused command codes return to idle there with
// no result. Pop and peek go on through a read state and an evaluate state.
// Display and search walk the single read port of the stack memory from the
// top, entry by entry (address, then registered read); back-pressure stalls it.
module bounded_stack_with_search
    import bsws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [2:0]  s_tuser,   // [2:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] data, [37:32] position, [39:38] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

`include "assert_macros.svh"

    bsws_cmd_t         ctl;
    bsws_status_t      sts;
    logic [DATA_W-1:0] out_data;
    logic [POS_W-1:0]  out_pos;

    bsws_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    bsws_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .in_cmd     (s_tuser),
        .in_value   (s_tdata),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (m_tuser),
        .out_data   (out_data),
        .out_pos    (out_pos),
        .out_last   (m_tlast)
    );

    assign m_tdata = {2'b00, out_pos, out_data};

    `ASSERT_CLK(a_fill_sane, !(sts.full && sts.empty), "stack both full and empty")
    `ASSERT_IMPL(a_emit_free, ctl.emit, sts.slot_free, "result written over pending one")
    `ASSERT_IMPL(a_write_room, ctl.mem_write, !sts.full, "write into full stack")
    `ASSERT_IMPL(a_pop_nonempty, ctl.fill_dec, !sts.empty, "pop from empty stack")

endmodule

// ----- tb/stack_reply_checker.sv -----
`timescale 1ns / 100ps
// Reply checker for the bounded stack: tracks the stack contents and compares every reply.
module stack_reply_checker
    import bsws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [2:0]  s_tuser,   // [2:0] cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [31:0] data, [37:32] position, [39:38] zero
    input  logic [1:0]  m_tuser,   // [1:0] status
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          replies_due
);

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [DATA_W-1:0] data;
        logic [POS_W-1:0]  position;
        logic              last;
    } stack_reply_t;

    logic [DATA_W-1:0] stack_words [DEPTH];
    int                stack_used;
    stack_reply_t      due_replies [$];

    function automatic stack_reply_t make_reply(logic [STS_W-1:0] status,
                                                logic [DATA_W-1:0] data,
                                                logic [POS_W-1:0] position,
                                                logic last);
        stack_reply_t r;
        r.status   = status;
        r.data     = data;
        r.position = position;
        r.last     = last;
        return r;
    endfunction

    task automatic apply_stack_command(input logic [CMD_W-1:0] op,
                                       input logic [DATA_W-1:0] key);
        int hit;
        hit = 0;
        if (op == CMD_PUSH) begin
            if (stack_used >= DEPTH)
                due_replies.push_back(make_reply(STS_FULL, '0, '0, 1'b1));
            else
            begin
                stack_words[stack_used] = key;
                stack_used++;
                due_replies.push_back(make_reply(STS_OK, '0, '0, 1'b1));
            end
        end
        else if (op == CMD_POP || op == CMD_PEEK || op == CMD_DISPLAY || op == CMD_SEARCH)
        begin
            if (stack_used == 0)
                due_replies.push_back(make_reply(STS_EMPTY, '0, '0, 1'b1));
            else if (op == CMD_POP)
            begin
                stack_used--;
                due_replies.push_back(make_reply(STS_OK, stack_words[stack_used], '0, 1'b1));
            end
            else if (op == CMD_PEEK)
                due_replies.push_back(make_reply(STS_OK, stack_words[stack_used-1], '0, 1'b1));
            else if (op == CMD_DISPLAY)
            begin
                for (int i = stack_used; i > 0; i--)
                    due_replies.push_back(make_reply(STS_OK, stack_words[i-1], '0, i == 1));
            end
            else
            begin
                for (int i = stack_used; i > 0 && hit == 0; i--)
                    if (stack_words[i-1] == key)
                        hit = i;
                if (hit != 0)
                    due_replies.push_back(make_reply(STS_OK, '0, hit[POS_W-1:0], 1'b1));
                else
                    due_replies.push_back(make_reply(STS_NOTFOUND, '0, '0, 1'b1));
            end
        end
    endtask

    always @(posedge clk)
    begin
        stack_reply_t want;
        if (!rst_n)
        begin
            mismatch_count = 0;
            stack_used     = 0;
            due_replies.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_replies.size() == 0)
                begin
                    mismatch_count++;
                    $display({"%0t: reply mismatch expected none, actual status=%0d ",
                              "data=%h pos=%0d last=%b"},
                             $time, m_tuser, m_tdata[31:0], m_tdata[37:32], m_tlast);
                end
                else
                begin
                    want = due_replies.pop_front();
                    if (m_tuser !== want.status || m_tdata[31:0] !== want.data
                        || m_tdata[37:32] !== want.position || m_tlast !== want.last
                        || m_tdata[39:38] !== 2'b00)
                    begin
                        mismatch_count++;
                        $display({"%0t: reply mismatch expected status=%0d data=%h pos=%0d ",
                                  "last=%b pad=0, actual status=%0d data=%h pos=%0d ",
                                  "last=%b pad=%b"},
                                 $time, want.status, want.data, want.position, want.last,
                                 m_tuser, m_tdata[31:0], m_tdata[37:32], m_tlast,
                                 m_tdata[39:38]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                apply_stack_command(s_tuser, s_tdata);
        end
        replies_due <= due_replies.size();
    end

endmodule

// ----- tb/tb_bounded_stack_with_search.sv -----
`timescale 1ns / 100ps
// Testbench top for the bounded stack: clock, reset, request stimulus, reply pacing and verdict.
module tb_bounded_stack_with_search;
    import bsws_pkg::*;

    typedef enum int { FILL_UP, DRAIN_DOWN, MIXED } load_kind_t;

    localparam int RANDOM_REQUESTS = 400;
    localparam int HOLD_CYCLES     = 300;
    localparam int STUCK_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 80;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] value
    logic [2:0]  s_tuser;   // [2:0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] data, [37:32] position, [39:38] zero
    logic [1:0]  m_tuser;   // [1:0] status
    logic        m_tlast;

    int mismatch_count;
    int replies_due;
    int stuck_cycles;
    int burst_left;
    bit valid_hi;
    bit steady_send;
    int hold_req;
    int hold_done;

    logic [31:0] key_pool [0:7] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                   32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555,
                                   32'hAAAA_AAAA, 32'h0000_0100};

    bounded_stack_with_search i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    stack_reply_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .replies_due    (replies_due)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("FAIL bounded_stack_with_search");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        logic [7:0] ready_pattern;
        int         slot;
        m_tready <= 1'b0;
        ready_pattern = 8'hFF;
        slot = 0;
        hold_done = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_done != hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = hold_req;
            end
            else
            begin
                if (slot % 64 == 0)
                begin
                    if ($urandom_range(0, 2) == 0)
                        ready_pattern = 8'hFF;
                    else
                        ready_pattern = $urandom | 8'h01;
                end
                m_tready <= ready_pattern[slot % 8];
                slot++;
            end
            @(posedge clk);
        end
    end

    task automatic set_valid(input bit level);
        if (valid_hi != level)
        begin
            s_tvalid <= level;
            valid_hi = level;
        end
    endtask

    task automatic send_request(input logic [2:0] op, input logic [31:0] value);
        set_valid(1'b1);
        s_tuser <= op;
        s_tdata <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (!steady_send)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(0, 15);
                set_valid(1'b0);
                repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 4))
                    @(posedge clk);
            end
        end
    endtask

    task automatic wait_replies_done();
        set_valid(1'b0);
        @(posedge clk);
        while (replies_due != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0, 1: return $urandom;
            2: return key_pool[$urandom_range(0, 7)];
            default: return $urandom_range(0, 5);
        endcase
    endfunction

    function automatic logic [2:0] pick_command(load_kind_t kind);
        int r;
        int push_pct;
        int pop_pct;
        r = $urandom_range(0, 99);
        push_pct = (kind == FILL_UP) ? 65 : (kind == DRAIN_DOWN) ? 20 : 35;
        pop_pct  = (kind == FILL_UP) ? 10 : (kind == DRAIN_DOWN) ? 55 : 30;
        if (r < 3)
            return CMD_SEARCH + 3'($urandom_range(1, 3));
        r -= 3;
        if (r < push_pct)
            return CMD_PUSH;
        r -= push_pct;
        if (r < pop_pct)
            return CMD_POP;
        r -= pop_pct;
        if (r < 6)
            return CMD_PEEK;
        if (r < 12)
            return CMD_DISPLAY;
        return CMD_SEARCH;
    endfunction

    initial
    begin
        load_kind_t  kind;
        logic [2:0]  op;
        int          sent;
        int          span;
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= CMD_PUSH;
        valid_hi    = 1'b0;
        steady_send = 1'b0;
        hold_req    = 0;
        burst_left  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(CMD_POP, 32'h0);
        send_request(CMD_PEEK, 32'h0);
        send_request(CMD_DISPLAY, 32'h0);
        send_request(CMD_SEARCH, 32'h7);
        send_request(CMD_PUSH, 32'h7FFF_FFFF);
        send_request(CMD_PUSH, 32'h8000_0000);
        send_request(CMD_PUSH, 32'h0000_0000);
        send_request(CMD_PUSH, 32'hFFFF_FFFF);
        send_request(CMD_PUSH, 32'h8000_0000);
        send_request(CMD_PEEK, 32'h0);
        send_request(CMD_DISPLAY, 32'h0);
        send_request(CMD_SEARCH, 32'h8000_0000);
        send_request(CMD_SEARCH, 32'hFFFF_FFFF);
        send_request(CMD_SEARCH, 32'h0000_3039);
        send_request(CMD_SEARCH + 3'd1, 32'hFFFF_FFFF);
        send_request(CMD_SEARCH + 3'd2, 32'h0);
        send_request(CMD_SEARCH + 3'd3, 32'h1234_5678);
        send_request(CMD_POP, 32'h0);
        send_request(CMD_POP, 32'h0);
        wait_replies_done();

        hold_req++;
        steady_send = 1'b1;
        for (int k = 0; k < 32; k++)
            send_request(CMD_PUSH, pick_value());
        send_request(CMD_DISPLAY, 32'h0);
        send_request(CMD_SEARCH, key_pool[$urandom_range(0, 7)]);
        steady_send = 1'b0;
        wait_replies_done();

        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            kind = load_kind_t'($urandom_range(0, 2));
            span = $urandom_range(20, 60);
            steady_send = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < span && sent < RANDOM_REQUESTS; k++)
            begin
                op = pick_command(kind);
                send_request(op, pick_value());
                if (op <= CMD_SEARCH)
                    sent++;
            end
            steady_send = 1'b0;
            if ($urandom_range(0, 2) == 0)
                wait_replies_done();
        end

        wait_replies_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && replies_due == 0)
            $display("PASS bounded_stack_with_search");
        else
            $display("FAIL bounded_stack_with_search");
        $finish;
    end

endmodule
